// File: rtl/core/keypad_matrix_scan_debounce_assert.svh
// Assertion macros for the keypad scanner.
`ifndef KEYPAD_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH
`define KEYPAD_MATRIX_SCAN_DEBOUNCE_ASSERT_SVH

`ifndef SYNTHESIS

`define KMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad scanner assertion failed");

`define KMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad scanner assertion failed");

`else

`define KMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define KMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/kms_pkg.sv
// Types, constants and helper functions for the keypad scanner.
`default_nettype none

package kms_pkg;

    localparam int ROW_COUNT = 4;
    localparam int COL_COUNT = 4;
    localparam int ROW_W     = 2;
    localparam int COL_W     = 2;
    localparam int SETTLE_W  = 8;
    localparam int DEBNC_W   = 20;
    localparam int CODE_W    = 4;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [SETTLE_W-1:0]  SETTLE_RST   = 8'd16;
    localparam logic [DEBNC_W-1:0]   DEBOUNCE_RST = 20'd100000;
    localparam logic [COL_COUNT-1:0] ALL_COLS     = 4'hF;

    // register index = byte address / 4
    localparam logic REG_SETTLE   = 1'b0;
    localparam logic REG_DEBOUNCE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'b001,
        PH_DEBOUNCE = 3'b010,
        PH_COLSCAN  = 3'b100
    } t_phase;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_ticks;
        logic [DEBNC_W-1:0]  debounce_ticks;
    } t_cfg;

    typedef struct packed {
        logic [COL_COUNT-1:0] col_drive;
        logic                 key_valid;
        logic [CODE_W-1:0]    key_code;
        logic                 scanning;
    } t_res;

    typedef struct packed {
        logic idle;
        logic colscan;
    } t_core_stat;

    // keypad legend, indexed by {row, col}
    localparam logic [CODE_W-1:0] LEGEND [16] = '{
        4'd1,  4'd2, 4'd3,  4'd10,
        4'd4,  4'd5, 4'd6,  4'd11,
        4'd7,  4'd8, 4'd9,  4'd12,
        4'd14, 4'd0, 4'd15, 4'd13
    };

    // mask of lines 0..idx
    function automatic logic [COL_COUNT-1:0] prefix_mask(input logic [COL_W-1:0] idx);
        logic [COL_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < COL_COUNT; i++) begin
            if (i <= int'(idx)) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] lowest_row(input logic [ROW_COUNT-1:0] rows);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int i = ROW_COUNT - 1; i >= 0; i--) begin
            if (rows[i]) begin
                r = ROW_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kms_if.sv
// Handshake channel interfaces for row samples and scan results.
`default_nettype none

interface kms_row_if
    import kms_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ROW_COUNT-1:0] row_sense;

    modport source (output valid, output row_sense, input ready);
    modport sink   (input valid, input row_sense, output ready);
endinterface

interface kms_res_if
    import kms_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [COL_COUNT-1:0] col_drive;
    logic                 key_valid;
    logic [CODE_W-1:0]    key_code;
    logic                 scanning;

    modport source (output valid, output col_drive, output key_valid, output key_code,
                    output scanning, input ready);
    modport sink   (input valid, input col_drive, input key_valid, input key_code,
                    input scanning, output ready);
endinterface

`default_nettype wire

// File: rtl/core/kms_cfg_regs.sv
// APB configuration registers: settle and debounce tick counts.
`default_nettype none

module kms_cfg_regs
    import kms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;
    logic reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_SETTLE:   n_cfg.settle_ticks   = pwdata[SETTLE_W-1:0];
                REG_DEBOUNCE: n_cfg.debounce_ticks = pwdata[DEBNC_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_ticks   <= SETTLE_RST;
            r_cfg.debounce_ticks <= DEBOUNCE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SETTLE:   prdata = {{(APB_DW-SETTLE_W){1'b0}}, r_cfg.settle_ticks};
            REG_DEBOUNCE: prdata = {{(APB_DW-DEBNC_W){1'b0}}, r_cfg.debounce_ticks};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/core/kms_scan_core.sv
// Scan state machine: settle, debounce and column search, one row sample per transfer.
`default_nettype none

module kms_scan_core
    import kms_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [ROW_COUNT-1:0] i_rows,
    input  wire t_cfg                 i_cfg,
    output t_res                      o_res,
    output t_core_stat                o_stat
);

    t_phase               r_phase, n_phase;
    logic [DEBNC_W-1:0]   r_wait,  n_wait;
    logic [ROW_W-1:0]     r_row,   n_row;
    logic [COL_W-1:0]     r_col,   n_col;
    logic [DEBNC_W-1:0]   settle_ext;
    logic [ROW_COUNT-1:0] rows_above;

    assign settle_ext = {{(DEBNC_W-SETTLE_W){1'b0}}, i_cfg.settle_ticks};
    assign rows_above = i_rows & ~prefix_mask(r_row);

    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_row   = r_row;
        n_col   = r_col;
        o_res.col_drive = ALL_COLS;
        o_res.key_valid = 1'b0;
        o_res.key_code  = '0;
        o_res.scanning  = 1'b0;
        case (r_phase)
            PH_DEBOUNCE: begin
                o_res.scanning = 1'b1;
                if (r_wait < i_cfg.debounce_ticks) begin
                    n_wait = r_wait + 1'b1;
                end else if (i_rows != '0) begin
                    n_row   = lowest_row(i_rows);
                    n_col   = '0;
                    n_wait  = '0;
                    n_phase = PH_COLSCAN;
                end else begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
            PH_COLSCAN: begin
                o_res.scanning  = 1'b1;
                o_res.col_drive = prefix_mask(r_col);
                if (r_wait < settle_ext) begin
                    n_wait = r_wait + 1'b1;
                end else if (i_rows[r_row]) begin
                    o_res.key_valid = 1'b1;
                    o_res.key_code  = LEGEND[{r_row, r_col}];
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end else if (r_col != COL_W'(COL_COUNT - 1)) begin
                    n_col  = r_col + 1'b1;
                    n_wait = '0;
                end else if (rows_above != '0) begin
                    n_row  = lowest_row(rows_above);
                    n_col  = '0;
                    n_wait = '0;
                end else begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
            default: begin
                if (r_wait < settle_ext) begin
                    n_wait = r_wait + 1'b1;
                end else if (i_rows != '0) begin
                    n_phase = PH_DEBOUNCE;
                    n_wait  = '0;
                end else begin
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_wait  <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign o_stat.idle    = (r_phase == PH_IDLE);
    assign o_stat.colscan = (r_phase == PH_COLSCAN);

endmodule

`default_nettype wire

// File: rtl/core/kms_out_skid.sv
// Result register with a spare entry; the input side waits only when both entries are full.
`default_nettype none

module kms_out_skid
    import kms_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_res  i_data,
    output logic       o_ready,
    kms_res_if.source  o_res
);

    t_res r_main;
    t_res r_spare;
    logic r_main_valid;
    logic r_spare_valid;
    logic pop;

    assign pop     = r_main_valid & o_res.ready;
    assign o_ready = ~r_spare_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid  <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (r_spare_valid) begin
            if (pop) begin
                r_spare_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_spare_valid <= 1'b1;
            end
            r_main_valid <= 1'b1;
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_spare_valid) begin
            if (pop) begin
                r_main <= r_spare;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_data;
            end else begin
                r_spare <= i_data;
            end
        end
    end

    assign o_res.valid     = r_main_valid;
    assign o_res.col_drive = r_main.col_drive;
    assign o_res.key_valid = r_main.key_valid;
    assign o_res.key_code  = r_main.key_code;
    assign o_res.scanning  = r_main.scanning;

endmodule

`default_nettype wire

// File: rtl/core/keypad_matrix_scan_debounce.sv
// Each row sample transfer registers one result; one sample per cycle while not stalled.
// The scan state advances once per accepted row sample, settle and debounce paced by counters.
// The output register has a spare entry, so input stalls only when both entries are full.
// Reset (synchronous, active low) gives idle with all columns driven, counters at zero,
// settle ticks 16 and debounce ticks 100000; the result buffer empties.
`default_nettype none

`include "keypad_matrix_scan_debounce_assert.svh"

module keypad_matrix_scan_debounce
    import kms_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    kms_row_if.sink                i_row,
    kms_res_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cfg       cfg;
    t_res       core_res;
    t_core_stat core_stat;
    logic       row_ready;
    logic       accept;

    assign i_row.ready = row_ready;
    assign accept      = i_row.valid & row_ready;

    kms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kms_scan_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_rows   (i_row.row_sense),
        .i_cfg    (cfg),
        .o_res    (core_res),
        .o_stat   (core_stat)
    );

    kms_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_res),
        .o_ready (row_ready),
        .o_res   (o_res)
    );

    // a reported key always returns the scanner to idle
    `KMS_ASSERT_NXT(a_key_then_idle, i_clk, i_rst_n, accept && core_res.key_valid, core_stat.idle)
    // input stalls only with the output buffer holding a result
    `KMS_ASSERT_IMP(a_stall_needs_data, i_clk, i_rst_n, !row_ready, o_res.valid)
    // a full buffer with no output transfer keeps the input stalled
    `KMS_ASSERT_NXT(a_full_holds, i_clk, i_rst_n, !row_ready && !o_res.ready, !row_ready)
    // partial column drive happens only during a column scan
    `KMS_ASSERT_IMP(a_drive_in_scan, i_clk, i_rst_n, core_res.col_drive != ALL_COLS,
                    core_stat.colscan)

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the keypad matrix scanner.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kms_pkg::*;

    localparam int LIMIT       = 1_000_000;
    localparam int RAND_ROUNDS = 8;
    localparam int ROUND_ITEMS = 50;

    localparam logic [APB_AW-1:0] ADDR_SETTLE   = {REG_SETTLE, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE, 2'b00};

    // legend by {row, col}
    localparam logic [CODE_W-1:0] KEY_CODE [16] = '{
        4'd1,  4'd2, 4'd3,  4'd10,
        4'd4,  4'd5, 4'd6,  4'd11,
        4'd7,  4'd8, 4'd9,  4'd12,
        4'd14, 4'd0, 4'd15, 4'd13
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    kms_row_if row_ch ();
    kms_res_if res_ch ();

    keypad_matrix_scan_debounce i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_row   (row_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // scanner state as predicted
    t_phase               scan_ph;
    logic [DEBNC_W-1:0]   wait_cnt;
    logic [ROW_W-1:0]     scan_row;
    logic [COL_W-1:0]     scan_col;
    logic [SETTLE_W-1:0]  settle_q;
    logic [DEBNC_W-1:0]   debounce_q;

    t_res pending_scans [$];
    int   errors       = 0;
    int   reports_seen = 0;
    int   items_sent   = 0;
    int   cycles       = 0;
    int   steady       = 0;
    int   hold_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic int next_row(input logic [ROW_COUNT-1:0] rows, input int from);
        for (int r = from; r < ROW_COUNT; r++) begin
            if (rows[r]) begin
                return r;
            end
        end
        return ROW_COUNT;
    endfunction

    function automatic logic [COL_COUNT-1:0] col_mask(input logic [COL_W-1:0] c);
        return COL_COUNT'((2 << c) - 1);
    endfunction

    function automatic logic [COL_COUNT-1:0] drive_now();
        return (scan_ph == PH_COLSCAN) ? col_mask(scan_col) : ALL_COLS;
    endfunction

    // rows seen with the given keys held under the present column drive
    function automatic logic [ROW_COUNT-1:0] key_rows(input logic [15:0] keys);
        logic [ROW_COUNT-1:0] rows;
        logic [COL_COUNT-1:0] drv;
        drv  = drive_now();
        rows = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            rows[r] = |(keys[r*COL_COUNT +: COL_COUNT] & drv);
        end
        return rows;
    endfunction

    function automatic void advance_scanner(input logic [ROW_COUNT-1:0] rows);
        t_res want;
        int   r;
        want           = '0;
        want.col_drive = ALL_COLS;
        case (scan_ph)
            PH_DEBOUNCE: begin
                want.scanning = 1'b1;
                if (wait_cnt < debounce_q) begin
                    wait_cnt = wait_cnt + 1'b1;
                end else if (rows != '0) begin
                    scan_row = ROW_W'(next_row(rows, 0));
                    scan_col = '0;
                    wait_cnt = '0;
                    scan_ph  = PH_COLSCAN;
                end else begin
                    scan_ph  = PH_IDLE;
                    wait_cnt = '0;
                end
            end
            PH_COLSCAN: begin
                want.scanning  = 1'b1;
                want.col_drive = col_mask(scan_col);
                if (wait_cnt < DEBNC_W'(settle_q)) begin
                    wait_cnt = wait_cnt + 1'b1;
                end else if (rows[scan_row]) begin
                    want.key_valid = 1'b1;
                    want.key_code  = KEY_CODE[{scan_row, scan_col}];
                    reports_seen++;
                    scan_ph  = PH_IDLE;
                    wait_cnt = '0;
                end else if (scan_col != COL_W'(COL_COUNT - 1)) begin
                    scan_col = scan_col + 1'b1;
                    wait_cnt = '0;
                end else begin
                    r = next_row(rows, int'(scan_row) + 1);
                    if (r < ROW_COUNT) begin
                        scan_row = ROW_W'(r);
                        scan_col = '0;
                        wait_cnt = '0;
                    end else begin
                        scan_ph  = PH_IDLE;
                        wait_cnt = '0;
                    end
                end
            end
            default: begin
                if (wait_cnt < DEBNC_W'(settle_q)) begin
                    wait_cnt = wait_cnt + 1'b1;
                end else if (rows != '0) begin
                    scan_ph  = PH_DEBOUNCE;
                    wait_cnt = '0;
                end else begin
                    scan_ph  = PH_IDLE;
                    wait_cnt = '0;
                end
            end
        endcase
        pending_scans.push_back(want);
    endfunction

    // result check first, then prediction of the row sample taken at this edge
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got.col_drive = res_ch.col_drive;
                got.key_valid = res_ch.key_valid;
                got.key_code  = res_ch.key_code;
                got.scanning  = res_ch.scanning;
                if (pending_scans.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected result col_drive %h key_valid %b",
                              " key_code %h scanning %b"},
                             $realtime, got.col_drive, got.key_valid, got.key_code,
                             got.scanning);
                end else begin
                    want = pending_scans.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display({"%0t: mismatch expected col_drive %h key_valid %b",
                                  " key_code %h scanning %b"},
                                 $realtime, want.col_drive, want.key_valid, want.key_code,
                                 want.scanning);
                        $display({"%0t:          actual col_drive %h key_valid %b",
                                  " key_code %h scanning %b"},
                                 $realtime, got.col_drive, got.key_valid, got.key_code,
                                 got.scanning);
                    end
                end
            end
            if (row_ch.valid && row_ch.ready) begin
                advance_scanner(row_ch.row_sense);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int w;
        res_ch.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                res_ch.ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            w = draw_gap();
            if (w > 0) begin
                res_ch.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // entered and left at a falling edge; valid stays up for a back-to-back transfer
    task automatic send_rows(input logic [ROW_COUNT-1:0] rows);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_ch.valid     <= 1'b1;
        row_ch.row_sense <= rows;
        @(posedge i_clk);
        while (!row_ch.ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic play_keys(input logic [15:0] keys, input int hold, input bit noisy);
        logic [ROW_COUNT-1:0] rows;
        for (int i = 0; i < hold; i++) begin
            rows = key_rows(keys);
            if (noisy && $urandom_range(0, 7) == 0) begin
                rows ^= ROW_COUNT'(1 << $urandom_range(0, ROW_COUNT - 1));
            end
            send_rows(rows);
        end
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] mask,
                             input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((got & mask) !== want) begin
            errors++;
            $display("%0t: register at %0d expected %h actual %h",
                     $realtime, addr, want, got & mask);
        end
    endtask

    // bring the scanner back to idle, let results drain, then reprogram
    task automatic set_timing(input logic [SETTLE_W-1:0] settle,
                              input logic [DEBNC_W-1:0] debounce);
        while (!(scan_ph == PH_IDLE && wait_cnt == '0)) send_rows('0);
        row_ch.valid <= 1'b0;
        while (pending_scans.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        apb_write(ADDR_SETTLE, ($urandom() & 32'hFFFF_FF00) | APB_DW'(settle));
        apb_write(ADDR_DEBOUNCE, ($urandom() & 32'hFFF0_0000) | APB_DW'(debounce));
        settle_q   = settle;
        debounce_q = debounce;
        check_reg(ADDR_SETTLE, 32'h0000_00FF, APB_DW'(settle));
        check_reg(ADDR_DEBOUNCE, 32'h000F_FFFF, APB_DW'(debounce));
    endtask

    task automatic test_reset_values();
        check_reg(ADDR_SETTLE, 32'h0000_00FF, APB_DW'(SETTLE_RST));
        check_reg(ADDR_DEBOUNCE, 32'h000F_FFFF, APB_DW'(DEBOUNCE_RST));
        // rows are driven only while the settle count runs, so the long default debounce is never entered
        for (int i = 0; i < 40; i++) begin
            send_rows((wait_cnt < DEBNC_W'(settle_q)) ? ROW_COUNT'($urandom()) : '0);
        end
    endtask

    task automatic test_directed_cases();
        logic [ROW_COUNT-1:0] seq [25] = '{
            4'h0,                               // idle, nothing pressed
            4'h1, 4'h1, 4'h1,                   // top-left key
            4'h1, 4'h0,                         // recheck fails
            4'h8, 4'h8, 4'h0, 4'h0, 4'h0, 4'h8, // bottom-right key
            4'hF, 4'hF, 4'hE, 4'hE, 4'hE, 4'hE, 4'hE, // no column in row 0, next row
            4'h4, 4'h4, 4'h0, 4'h0, 4'h0, 4'h0  // no column anywhere
        };
        set_timing('0, '0);
        steady = 0;
        foreach (seq[i]) begin
            send_rows(seq[i]);
        end
    endtask

    task automatic test_slow_settle();
        int start;
        set_timing(8'hFF, '0);
        steady = 1;
        start  = reports_seen;
        while (reports_seen == start) send_rows(key_rows(16'h1000));
        steady = 0;
    endtask

    task automatic test_long_debounce();
        set_timing(8'hFF, 20'hFFFFF);
        for (int i = 0; i < 256; i++) begin
            send_rows('0);
        end
    endtask

    task automatic test_random_keys();
        int          s;
        int          d;
        int          full;
        int          target;
        logic [15:0] keys;
        for (int round = 0; round < RAND_ROUNDS; round++) begin
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
            d = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 4);
            set_timing(SETTLE_W'(s), DEBNC_W'(d));
            steady = (round % 3 == 1);
            target = items_sent + ROUND_ITEMS;
            full   = 5 * (s + 1) + d + 3;
            while (items_sent < target) begin
                keys = 16'(1 << $urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(1, 10)) send_rows(ROW_COUNT'($urandom()));
                    end
                    1, 2: begin
                        play_keys(keys, $urandom_range(1, full), 1'b1);
                    end
                    default: begin
                        if ($urandom_range(0, 3) == 0) begin
                            keys |= 16'(1 << $urandom_range(0, 15));
                        end
                        play_keys(keys, full + $urandom_range(0, full),
                                  $urandom_range(0, 3) == 0);
                    end
                endcase
                repeat ($urandom_range(0, s + 3)) send_rows('0);
            end
        end
        steady = 0;
    endtask

    task automatic test_backpressure();
        set_timing(8'd1, 20'd2);
        steady      = 1;
        hold_cycles = 300;
        play_keys(16'(1 << $urandom_range(0, 15)), 200, 1'b0);
        steady = 0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        row_ch.valid     = 1'b0;
        row_ch.row_sense = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        settle_q         = SETTLE_RST;
        debounce_q       = DEBOUNCE_RST;
        scan_ph          = PH_IDLE;
        wait_cnt         = '0;
        scan_row         = '0;
        scan_col         = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_values();
        test_directed_cases();
        test_slow_settle();
        test_long_debounce();
        test_random_keys();
        test_backpressure();

        row_ch.valid <= 1'b0;
        while (pending_scans.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
